// ===== hw/rtl/cfc_pkg.sv =====
// Shared types and constants for the certainty factor combiner.
`default_nettype none

package cfc_pkg;

  // Width of every certainty factor field on the channels
  localparam int CF_W = 16;

  // One certainty factor as it travels on a channel
  typedef logic signed [CF_W-1:0] cf_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfc_if.sv =====
// Stream interfaces for the operand pair request and the combined result.
`default_nettype none

interface cfc_in_if;
  logic         valid;
  logic         ready;
  cfc_pkg::cf_t first_cf;
  cfc_pkg::cf_t second_cf;

  modport source (output valid, output first_cf, output second_cf, input ready);
  modport sink   (input valid, input first_cf, input second_cf, output ready);
endinterface

interface cfc_out_if;
  logic         valid;
  logic         ready;
  cfc_pkg::cf_t combined_cf;

  modport source (output valid, output combined_cf, input ready);
  modport sink   (input valid, input combined_cf, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/certainty_factor_combiner.sv =====
// Pipelined MYCIN certainty factor combiner with a bit-per-stage divider.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------
//  in_ch   | in  | valid / ready | first_cf, second_cf (signed, Q.FRAC_BITS)
//  out_ch  | out | valid / ready | combined_cf (signed, Q.FRAC_BITS)
//
// One request enters per cycle while no result on out_ch is refused; each passes
// three front stages, FRAC_BITS + 1 restoring divider stages that each settle
// one quotient bit, and the output register.
// rst_n clears the stage valid bits only.
// A result held on out_ch stalls the whole pipeline in place; in_ch.ready
// is low only while that result is not taken.
`default_nettype none

module certainty_factor_combiner #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  cfc_in_if.sink         in_ch,
  cfc_out_if.source      out_ch
);

  // Internal signed width for saturated inputs and results
  localparam int VW = (FRAC_BITS + 2 > cfc_pkg::CF_W) ? FRAC_BITS + 2 : cfc_pkg::CF_W;
  // Magnitude width, holds 0 .. ONE
  localparam int MW = FRAC_BITS + 1;
  // Divider remainder width, holds twice a remainder below ONE
  localparam int RW = MW + 1;
  localparam int PW = 2 * MW;
  localparam int DS = FRAC_BITS + 1;

  localparam logic signed [VW-1:0] ONE_S = VW'(1) << FRAC_BITS;
  localparam logic [MW-1:0]        ONE_M = MW'(1) << FRAC_BITS;

  logic adv;

  // Advance everything unless the held result is refused
  assign adv         = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = adv;

  // ---------------- stage 1: saturate inputs ----------------
  logic signed [VW-1:0] a_ext, b_ext, a_sat, b_sat;
  logic signed [VW-1:0] a1_r, b1_r;
  logic                 v1_r;

  assign a_ext = VW'(in_ch.first_cf);
  assign b_ext = VW'(in_ch.second_cf);
  assign a_sat = (a_ext > ONE_S) ? ONE_S : ((a_ext < -ONE_S) ? -ONE_S : a_ext);
  assign b_sat = (b_ext > ONE_S) ? ONE_S : ((b_ext < -ONE_S) ? -ONE_S : b_ext);

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= a_sat;
      b1_r <= b_sat;
    end
  end

  // ---------------- stage 2: magnitudes, signs, sum ----------------
  logic [VW-1:0]        a_abs, b_abs;
  logic [MW-1:0]        ma2_r, mb2_r;
  logic                 sa2_r, sb2_r;
  logic signed [VW:0]   sum2_r;
  logic signed [VW-1:0] a2_r;
  logic                 v2_r;

  assign a_abs = a1_r[VW-1] ? VW'(-a1_r) : VW'(a1_r);
  assign b_abs = b1_r[VW-1] ? VW'(-b1_r) : VW'(b1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ma2_r  <= a_abs[MW-1:0];
      mb2_r  <= b_abs[MW-1:0];
      sa2_r  <= a1_r[VW-1];
      sb2_r  <= b1_r[VW-1];
      sum2_r <= (VW+1)'(a1_r) + (VW+1)'(b1_r);
      a2_r   <= a1_r;
    end
  end

  // ---------------- stage 3: product, divisor, dividend ----------------
  logic [MW-1:0]        m_min, d_val, one_less_a;
  logic [VW:0]          sum_abs;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        prod3_r;
  logic signed [VW-1:0] a3_r;
  logic                 sb3_r, same3_r, zero3_r, ssgn3_r;
  logic [MW-1:0]        d3_r, ms3_r;
  logic                 v3_r;

  assign m_min      = (ma2_r < mb2_r) ? ma2_r : mb2_r;
  assign d_val      = ONE_M - m_min;
  assign sum_abs    = sum2_r[VW] ? (VW+1)'(-sum2_r) : (VW+1)'(sum2_r);
  // Same-sign term uses |b| * (ONE - |a|) for both sign cases
  assign one_less_a = ONE_M - ma2_r;
  assign prod       = PW'(mb2_r) * PW'(one_less_a);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= prod;
      a3_r    <= a2_r;
      sb3_r   <= sb2_r;
      same3_r <= (sa2_r == sb2_r);
      zero3_r <= (m_min == ONE_M);
      ssgn3_r <= sum2_r[VW];
      d3_r    <= d_val;
      ms3_r   <= sum_abs[MW-1:0];
    end
  end

  // ---------------- divider stages, one quotient bit each ----------------
  logic [RW-1:0]        rem_r  [DS];
  logic [MW-1:0]        q_r    [DS];
  logic [MW-1:0]        d_r    [DS];
  logic signed [VW-1:0] res_r  [DS];
  logic                 same_r [DS];
  logic                 zero_r [DS];
  logic                 ssgn_r [DS];
  logic                 v_r    [DS];

  logic [MW-1:0]        pq;
  logic signed [VW-1:0] pq_s, same_res;
  logic                 ge0;

  // Finish the same-sign result: a + sign(b) * trunc(product / ONE)
  assign pq       = prod3_r[FRAC_BITS +: MW];
  assign pq_s     = VW'({1'b0, pq});
  assign same_res = a3_r + (sb3_r ? -pq_s : pq_s);
  // Top quotient bit: for opposite signs, set only when |a+b| equals the divisor
  assign ge0      = (ms3_r >= d3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= ge0 ? RW'(ms3_r - d3_r) : RW'(ms3_r);
      q_r[0]    <= MW'(ge0);
      d_r[0]    <= d3_r;
      res_r[0]  <= same_res;
      same_r[0] <= same3_r;
      zero_r[0] <= zero3_r;
      ssgn_r[0] <= ssgn3_r;
    end
  end

  for (genvar k = 1; k < DS; k++) begin : g_div
    logic [RW-1:0] r2;
    logic          ge;

    assign r2 = {rem_r[k-1][RW-2:0], 1'b0};
    assign ge = (r2 >= RW'(d_r[k-1]));

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? (r2 - RW'(d_r[k-1])) : r2;
        q_r[k]    <= {q_r[k-1][MW-2:0], ge};
        d_r[k]    <= d_r[k-1];
        res_r[k]  <= res_r[k-1];
        same_r[k] <= same_r[k-1];
        zero_r[k] <= zero_r[k-1];
        ssgn_r[k] <= ssgn_r[k-1];
      end
    end
  end

  // ---------------- output stage: pick and sign the result ----------------
  logic signed [VW-1:0] q_s, res_nxt;
  cfc_pkg::cf_t         out_cf_r;
  logic                 out_valid_r;

  assign q_s = VW'({1'b0, q_r[DS-1]});

  always_comb begin
    if (same_r[DS-1]) begin
      res_nxt = res_r[DS-1];
    end else if (zero_r[DS-1]) begin
      res_nxt = '0;
    end else begin
      res_nxt = ssgn_r[DS-1] ? -q_s : q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cf_r <= cfc_pkg::cf_t'(res_nxt[cfc_pkg::CF_W-1:0]);
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v3_r;
    end
  end

  for (genvar k = 1; k < DS; k++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.combined_cf = out_cf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cfc_checker.sv =====
// Port-level checks for the certainty factor combiner, bound to the top level.
`default_nettype none

module cfc_checker #(
  parameter int FRAC_BITS = 14
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire cfc_pkg::cf_t combined_cf
);

  localparam int ONE_I = 1 << FRAC_BITS;

  // Input may only be held off by a refused result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input request refused without a pending result stall");

  // A result never leaves the -1.0 .. 1.0 range when it fits the field
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((FRAC_BITS > 14) ||
                   ((int'(combined_cf) <= ONE_I) && (int'(combined_cf) >= -ONE_I))))
    else $error("combined certainty factor out of range");

  // Hold a refused result
  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(combined_cf))
    else $error("result payload changed while stalled");

endmodule

bind certainty_factor_combiner cfc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_cfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .combined_cf (out_ch.combined_cf)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the certainty factor combiner: directed and random operand pairs.

typedef struct packed {
  cfc_pkg::cf_t first_cf;
  cfc_pkg::cf_t second_cf;
  cfc_pkg::cf_t combined_cf;
} cf_request_t;

// Predict combined factors and match them against the result channel in order
class cf_result_tracker;
  cf_request_t pending[$];
  longint      one;
  int          mismatches;

  function new(int frac_bits);
    one        = longint'(1) << frac_bits;
    mismatches = 0;
  endfunction

  // Saturate a raw field to -1.0 .. 1.0
  function longint clamp_cf(cfc_pkg::cf_t raw);
    longint v;
    v = raw;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  // MYCIN rule; products and quotient truncate toward zero
  function cfc_pkg::cf_t mycin_combine(cfc_pkg::cf_t first_cf, cfc_pkg::cf_t second_cf);
    longint a, b, m, r;
    a = clamp_cf(first_cf);
    b = clamp_cf(second_cf);
    if (a >= 0 && b >= 0) begin
      r = a + (b * (one - a)) / one;
    end else if (a < 0 && b < 0) begin
      r = a + (b * (one + a)) / one;
    end else begin
      m = (a < 0) ? -a : a;
      if (((b < 0) ? -b : b) < m) m = (b < 0) ? -b : b;
      // full certainty on both sides cancels out
      if (m >= one) r = 0;
      else r = ((a + b) * one) / (one - m);
    end
    return cfc_pkg::cf_t'(r);
  endfunction

  function void note_request(cfc_pkg::cf_t first_cf, cfc_pkg::cf_t second_cf);
    cf_request_t req;
    req.first_cf    = first_cf;
    req.second_cf   = second_cf;
    req.combined_cf = mycin_combine(first_cf, second_cf);
    pending.push_back(req);
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_result(cfc_pkg::cf_t got);
    cf_request_t req;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("result %0d with no request waiting", got));
      return;
    end
    req = pending.pop_front();
    if (got !== req.combined_cf)
      report_mismatch($sformatf("a=%0d b=%0d combined_cf got %0d want %0d",
                                req.first_cf, req.second_cf, got, req.combined_cf));
  endtask
endclass

module testbench;
  typedef cfc_pkg::cf_t cf_t;

  localparam int  FRAC_BITS    = 14;
  localparam int  ONE_INT      = 1 << FRAC_BITS;
  localparam cf_t CF_ONE       = cf_t'(ONE_INT);
  localparam int  RANDOM_PAIRS = 1750;
  localparam int  TAIL_CYCLES  = FRAC_BITS + 25;
  localparam int  CYCLE_LIMIT  = 500000;

  typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   hold_request = 0;
  int   hold_left = 0;

  cf_result_tracker results;

  cfc_in_if  in_ch ();
  cfc_out_if out_ch ();

  certainty_factor_combiner #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Offer one pair and hold it until the block takes it
  task automatic send_pair(cf_t first_cf, cf_t second_cf);
    in_ch.valid     <= 1'b1;
    in_ch.first_cf  <= first_cf;
    in_ch.second_cf <= second_cf;
    do @(posedge clk); while (!in_ch.ready);
    results.note_request(first_cf, second_cf);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every request has its result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results.pending.size() != 0);
  endtask

  // Mostly in-range values, with extremes, near-certain values and raw bit patterns
  function automatic cf_t random_cf();
    int pick;
    int off;
    pick = $urandom_range(0, 15);
    off  = $urandom_range(0, 40);
    case (pick)
      0: return cf_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return CF_ONE;
          1: return -CF_ONE;
          2: return cf_t'(1);
          3: return cf_t'(-1);
          default: return cf_t'(0);
        endcase
      end
      2, 3: return ($urandom_range(0, 1) != 0) ? cf_t'(ONE_INT - off) : cf_t'(off - ONE_INT);
      default: return cf_t'(int'($urandom_range(0, 2 * ONE_INT)) - ONE_INT);
    endcase
  endfunction

  // Result side: check taken results, then pick the next ready level
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    logic     next_ready;
    out_ch.ready = 1'b0;
    mode         = RX_OPEN;
    mode_left    = 0;
    phase        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) results.check_result(out_ch.combined_cf);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      phase++;
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     next_ready = 1'b1;
          RX_LIGHT:    next_ready = ($urandom_range(0, 3) != 0);
          RX_PERIODIC: next_ready = (phase % 3 != 0);
          default:     next_ready = ($urandom_range(0, 9) < 3);
        endcase
      end
      out_ch.ready <= next_ready && rst_n;
    end
  end

  // Request side
  initial begin
    int  sent;
    int  burst;
    bit  hold_done;
    bit  drain_done;
    results = new(FRAC_BITS);
    in_ch.valid     = 1'b0;
    in_ch.first_cf  = '0;
    in_ch.second_cf = '0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each rule, full certainty, zero, saturation of raw values
    send_pair(cf_t'(0), cf_t'(0));
    send_pair(CF_ONE, CF_ONE);
    send_pair(-CF_ONE, -CF_ONE);
    send_pair(CF_ONE, -CF_ONE);
    send_pair(-CF_ONE, CF_ONE);
    send_pair(CF_ONE, cf_t'(0));
    send_pair(cf_t'(0), -CF_ONE);
    send_pair(cf_t'(-1), cf_t'(1));
    send_pair(cf_t'(0), cf_t'(-1));
    send_pair(cf_t'(-1), cf_t'(0));
    send_pair(cf_t'(8192), cf_t'(-8192));
    send_pair(cf_t'(8192), cf_t'(8192));
    send_pair(cf_t'(-8192), cf_t'(-8192));
    send_pair(cf_t'(16'sh7fff), cf_t'(16'sh8000));
    send_pair(cf_t'(16'sh8000), cf_t'(5000));
    send_pair(cf_t'(16'sh7fff), cf_t'(16'sh7fff));
    send_pair(cf_t'(20000), cf_t'(-3000));
    send_pair(cf_t'(-20000), cf_t'(-20000));
    send_pair(cf_t'(ONE_INT - 1), -CF_ONE);
    send_pair(-CF_ONE, cf_t'(ONE_INT - 1));
    send_pair(cf_t'(1), cf_t'(1 - ONE_INT));
    send_pair(cf_t'(1 - ONE_INT), cf_t'(ONE_INT - 1));
    send_pair(cf_t'(12345), cf_t'(-6789));
    send_pair(CF_ONE, cf_t'(-100));
    wait_drained();

    // Random bursts with gaps, one long result hold-off and one full drain
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      burst = $urandom_range(1, 48);
      repeat (burst) send_pair(random_cf(), random_cf());
      sent += burst;
      if (!hold_done && sent >= 600) begin
        hold_done    = 1'b1;
        hold_request = 400;
        repeat (80) send_pair(random_cf(), random_cf());
        sent += 80;
      end
      if (!drain_done && sent >= 1200) begin
        drain_done = 1'b1;
        wait_drained();
      end
      idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results.mismatches == 0 && results.pending.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_if.sv
hw/rtl/certainty_factor_combiner.sv
hw/rtl/cfc_checker.sv
test/testbench.sv
